/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of the key debounce block.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define AST_SAME(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define AST_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/mkdb_pkg.sv */
// Types, constants and register codes of the multi-key debounce block.
// No dependencies; every other file but the macro header imports it.
package mkdb_pkg;

  localparam int NUM_KEYS  = 8;
  localparam int TIME_BITS = 16;
  localparam int KEY_W     = $clog2(NUM_KEYS);
  localparam int CODE_W    = 3;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  localparam logic [TIME_BITS-1:0] DEBOUNCE_RST = TIME_BITS'(10);
  localparam logic [TIME_BITS-1:0] LONG_RST     = TIME_BITS'(1500);
  localparam logic [NUM_KEYS-1:0]  ENABLE_RST   = NUM_KEYS'(8'hDF);

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_LONG     = 2'd1;
  localparam logic [1:0] REG_ENABLE   = 2'd2;

  localparam logic [CODE_W-1:0] EV_NONE    = 3'd0;
  localparam logic [CODE_W-1:0] EV_PRESS   = 3'd1;
  localparam logic [CODE_W-1:0] EV_LONG    = 3'd2;
  localparam logic [CODE_W-1:0] EV_RELEASE = 3'd3;
  localparam logic [CODE_W-1:0] EV_IDLE    = 3'd4;

  typedef struct packed {
    logic [NUM_KEYS-1:0]  raw_keys;
    logic [TIME_BITS-1:0] now_ms;
  } in_beat_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key_index;
    logic [CODE_W-1:0] event_code;
    logic              last_event;
  } out_beat_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] debounce_ms;
    logic [TIME_BITS-1:0] long_ms;
    logic [NUM_KEYS-1:0]  event_enable;
  } cfg_t;

  // One entry of the per-key state memory.
  typedef struct packed {
    logic [TIME_BITS-1:0] press_stamp;
    logic [TIME_BITS-1:0] release_stamp;
    logic                 press_armed;
    logic                 release_armed;
  } key_state_t;

  // Event handed from the update stage to the output stage.
  typedef struct packed {
    logic              load;
    logic              scan_end;
    logic [KEY_W-1:0]  key;
    logic [CODE_W-1:0] code;
  } upd_event_t;

endpackage

/* rtl/mkdb_cfg.sv */
// Configuration registers behind the APB-style port.
// Depends on mkdb_pkg.
module mkdb_cfg
  import mkdb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [TIME_BITS-1:0] debounce_r;
  logic [TIME_BITS-1:0] long_r;
  logic [NUM_KEYS-1:0]  enable_r;
  logic [1:0]           reg_idx;

  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RST;
      long_r     <= LONG_RST;
      enable_r   <= ENABLE_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_DEBOUNCE: debounce_r <= pwdata[TIME_BITS-1:0];
        REG_LONG:     long_r     <= pwdata[TIME_BITS-1:0];
        REG_ENABLE:   enable_r   <= pwdata[NUM_KEYS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DEBOUNCE: prdata = DATA_W'(debounce_r);
      REG_LONG:     prdata = DATA_W'(long_r);
      REG_ENABLE:   prdata = DATA_W'(enable_r);
      default:      prdata = '0;
    endcase
  end

  assign cfg.debounce_ms  = debounce_r;
  assign cfg.long_ms      = long_r;
  assign cfg.event_enable = enable_r;

endmodule

/* rtl/mkdb_mem.sv */
// Per-key state memory: one write port, one registered read port.
// Depends on mkdb_pkg. Entries read as zero until first written.
module mkdb_mem
  import mkdb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [KEY_W-1:0] rd_addr,
  output key_state_t       rd_data,
  input  logic             wr_en,
  input  logic [KEY_W-1:0] wr_addr,
  input  key_state_t       wr_data
);

  key_state_t          mem [NUM_KEYS];
  logic [NUM_KEYS-1:0] valid_r;
  key_state_t          rdata_r;
  logic                rvalid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A read of the entry being written in the same cycle takes the new data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rdata_r <= wr_data;
      end else begin
        rdata_r <= mem[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (rd_en) begin
        rvalid_r <= valid_r[rd_addr] || (wr_en && (wr_addr == rd_addr));
      end
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rvalid_r ? rdata_r : '0;

endmodule

/* rtl/mkdb_upd.sv */
// Debounce and long-hold update of one key: next memory entry, next level, event.
// Depends on mkdb_pkg; purely combinational.
module mkdb_upd
  import mkdb_pkg::*;
(
  input  key_state_t           state,
  input  logic                 raw_bit,
  input  logic                 stable_bit,
  input  logic [TIME_BITS-1:0] now,
  input  logic [TIME_BITS-1:0] debounce_ms,
  input  logic [TIME_BITS-1:0] long_ms,
  output key_state_t           state_nxt,
  output logic                 stable_nxt,
  output logic [CODE_W-1:0]    code
);

  logic [TIME_BITS-1:0] press_age;
  logic [TIME_BITS-1:0] release_age;
  logic [TIME_BITS-1:0] press_stamp_eff;
  logic [TIME_BITS-1:0] release_stamp_eff;

  // A changing key takes its stamp from this scan if not armed yet.
  assign press_stamp_eff   = state.press_armed   ? state.press_stamp   : now;
  assign release_stamp_eff = state.release_armed ? state.release_stamp : now;
  assign press_age         = now - press_stamp_eff;
  assign release_age       = now - release_stamp_eff;

  always_comb begin
    state_nxt  = state;
    stable_nxt = stable_bit;
    code       = EV_NONE;
    if (raw_bit != stable_bit) begin
      if (raw_bit) begin
        state_nxt.press_stamp = press_stamp_eff;
        state_nxt.press_armed = 1'b1;
        if (press_age >= debounce_ms) begin
          state_nxt.release_armed = 1'b0;
          stable_nxt              = 1'b1;
          code                    = EV_PRESS;
        end
      end else begin
        state_nxt.release_stamp = release_stamp_eff;
        state_nxt.release_armed = 1'b1;
        if (release_age >= debounce_ms) begin
          state_nxt.press_armed = 1'b0;
          stable_nxt            = 1'b0;
          code                  = EV_RELEASE;
        end
      end
    end else if (stable_bit) begin
      if (state.press_armed && (press_age >= long_ms)) begin
        state_nxt.press_armed = 1'b0;
        code                  = EV_LONG;
      end
    end else begin
      if (state.release_armed && (release_age >= long_ms)) begin
        state_nxt.release_armed = 1'b0;
        code                    = EV_IDLE;
      end
    end
  end

endmodule

/* rtl/mkdb_out.sv */
// Output stage: holds one event back so the last one of a scan can be marked.
// Depends on mkdb_pkg.
module mkdb_out
  import mkdb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  upd_event_t ev,
  output logic       can_take,
  output logic       out_valid,
  input  logic       out_stall,
  output out_beat_t  out_data
);

  logic              pend_v_r;
  logic              pend_last_r;
  logic [KEY_W-1:0]  pend_key_r;
  logic [CODE_W-1:0] pend_code_r;
  logic              out_valid_r;
  out_beat_t         out_data_r;
  logic              out_free;
  logic              pend_move;

  assign out_free  = !out_valid_r || !out_stall;
  // The held event leaves once a newer one arrives or its scan has ended.
  assign pend_move = pend_v_r && out_free && (pend_last_r || ev.load);
  assign can_take  = !pend_v_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r    <= 1'b0;
      pend_last_r <= 1'b0;
    end else if (ev.load) begin
      pend_v_r    <= 1'b1;
      pend_last_r <= ev.scan_end;
    end else if (pend_move) begin
      pend_v_r    <= 1'b0;
      pend_last_r <= 1'b0;
    end else if (ev.scan_end && pend_v_r) begin
      pend_last_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ev.load) begin
      pend_key_r  <= ev.key;
      pend_code_r <= ev.code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pend_move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_move) begin
      out_data_r.key_index  <= pend_key_r;
      out_data_r.event_code <= pend_code_r;
      out_data_r.last_event <= pend_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/multi_key_debounce_long_press.sv */
// Eight-key debounce with press, release, long-hold and idle events.
// A scan beat visits the keys one per cycle while the output is not stalled,
// each as a read-modify-write of its entry in the per-key state memory; the
// next scan is accepted in the cycle the last key of the current one is read.
// Events leave one per cycle while not stalled, in rising key order, the last
// of a scan marked. An event goes from the update stage via the pending
// register to the output register, held until the next event of the scan or
// the end of the scan is known, so an event followed only by quiet keys waits
// for the last key. A stalled output holds up the key walk. No clearing pass
// is needed after reset. Built from mkdb_pkg and the mkdb_* submodules.
module multi_key_debounce_long_press
  import mkdb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_beat_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_beat_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t                 cfg;
  logic                 a_valid_r;
  in_beat_t             a_beat_r;
  logic [KEY_W-1:0]     a_key_r;
  logic                 a_last;
  logic                 a_go;
  logic                 b_valid_r;
  logic                 b_raw_r;
  logic [TIME_BITS-1:0] b_now_r;
  logic [KEY_W-1:0]     b_key_r;
  logic                 b_end_r;
  logic                 b_go;
  logic [NUM_KEYS-1:0]  stable_r;
  key_state_t           rd_state;
  key_state_t           state_nxt;
  logic                 stable_nxt;
  logic [CODE_W-1:0]    code;
  logic                 can_take;
  logic                 in_acc;
  upd_event_t           ev;

  mkdb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign b_go   = b_valid_r && can_take;
  assign a_go   = a_valid_r && (!b_valid_r || b_go);
  assign a_last = (a_key_r == KEY_W'(NUM_KEYS - 1));

  assign in_stall = a_valid_r && !(a_go && a_last);
  assign in_acc   = in_valid && !in_stall;

  // Read stage: walks the keys of the held scan.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      a_key_r   <= '0;
    end else if (in_acc) begin
      a_valid_r <= 1'b1;
      a_key_r   <= '0;
    end else if (a_go) begin
      if (a_last) begin
        a_valid_r <= 1'b0;
      end else begin
        a_key_r <= a_key_r + KEY_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_beat_r <= in_data;
    end
  end

  mkdb_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (a_go),
    .rd_addr (a_key_r),
    .rd_data (rd_state),
    .wr_en   (b_go),
    .wr_addr (b_key_r),
    .wr_data (state_nxt)
  );

  // Update stage: memory data arrives here in the cycle after the read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (a_go) begin
      b_valid_r <= 1'b1;
    end else if (b_go) begin
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go) begin
      b_raw_r <= a_beat_r.raw_keys[a_key_r];
      b_now_r <= a_beat_r.now_ms;
      b_key_r <= a_key_r;
      b_end_r <= a_last;
    end
  end

  mkdb_upd u_upd (
    .state       (rd_state),
    .raw_bit     (b_raw_r),
    .stable_bit  (stable_r[b_key_r]),
    .now         (b_now_r),
    .debounce_ms (cfg.debounce_ms),
    .long_ms     (cfg.long_ms),
    .state_nxt   (state_nxt),
    .stable_nxt  (stable_nxt),
    .code        (code)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= '0;
    end else if (b_go) begin
      stable_r[b_key_r] <= stable_nxt;
    end
  end

  assign ev.load     = b_go && (code != EV_NONE) && cfg.event_enable[b_key_r];
  assign ev.scan_end = b_go && b_end_r;
  assign ev.key      = b_key_r;
  assign ev.code     = code;

  mkdb_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev        (ev),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* rtl/mkdb_chk.sv */
// Port-level checker for the multi-key debounce block, bound to its top level.
// Depends on mkdb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mkdb_chk
  import mkdb_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input in_beat_t          in_data,
  input logic              out_valid,
  input logic              out_stall,
  input out_beat_t         out_data,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [ADDR_W-1:0] paddr,
  input logic [DATA_W-1:0] pwdata,
  input logic              pready
);

  logic [KEY_W-1:0]    prev_key_r;
  logic                scan_open_r;
  logic [NUM_KEYS-1:0] enable_r;
  logic                out_beat;
  logic                code_ok;

  assign out_beat = out_valid && !out_stall;
  assign code_ok  = (out_data.event_code == EV_PRESS) || (out_data.event_code == EV_LONG) ||
                    (out_data.event_code == EV_RELEASE) || (out_data.event_code == EV_IDLE);

  // Shadow of the enable mask and of the scan in progress on the output.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= ENABLE_RST;
      scan_open_r <= 1'b0;
      prev_key_r  <= '0;
    end else begin
      if (psel && penable && pwrite && pready && (paddr[3:2] == REG_ENABLE)) begin
        enable_r <= pwdata[NUM_KEYS-1:0];
      end
      if (out_beat) begin
        scan_open_r <= !out_data.last_event;
        prev_key_r  <= out_data.key_index;
      end
    end
  end

  `AST_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data))

  `AST_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  `AST_SAME(a_code_real, out_valid, code_ok)

  `AST_SAME(a_key_order, out_valid && scan_open_r, out_data.key_index > prev_key_r)

  `AST_SAME(a_key_enabled, out_valid, enable_r[out_data.key_index])

endmodule

bind multi_key_debounce_long_press mkdb_chk u_chk (.*);
